### hw/rtl/sdp_pkg.sv
// Shared types and constants for the selector danger prescan unit.
`timescale 1ns / 1ps

package sdp_pkg;

	localparam int NUM_FLAGS = 9;

	localparam int FB_IMPORTANT = 0;
	localparam int FB_MARKUP    = 1;
	localparam int FB_AT        = 2;
	localparam int FB_EXPR      = 3;
	localparam int FB_URL       = 4;
	localparam int FB_ESCAPE    = 5;
	localparam int FB_COMMENT   = 6;
	localparam int FB_BANG      = 7;
	localparam int FB_COMMA     = 8;

	localparam logic [3:0] V_PASS      = 4'd0;
	localparam logic [3:0] V_EMPTY     = 4'd1;
	localparam logic [3:0] V_TOO_LONG  = 4'd2;
	localparam logic [3:0] V_IMPORTANT = 4'd3;
	localparam logic [3:0] V_MARKUP    = 4'd4;
	localparam logic [3:0] V_AT_RULE   = 4'd5;
	localparam logic [3:0] V_EXPR      = 4'd6;
	localparam logic [3:0] V_URL       = 4'd7;
	localparam logic [3:0] V_ESCAPE    = 4'd8;
	localparam logic [3:0] V_COMMENT   = 4'd9;
	localparam logic [3:0] V_BANG      = 4'd10;
	localparam logic [3:0] V_LIST      = 4'd11;

	localparam logic [79:0] PAT_IMPORTANT = "!important";
	localparam logic [87:0] PAT_EXPR      = "expression(";
	localparam logic [31:0] PAT_URL       = "url(";
	localparam logic [79:0] PAT_IMAGE_SET = "image-set(";
	localparam logic [87:0] PAT_JS        = "javascript:";

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_BANG  = "!";
	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_STAR  = "*";
	localparam logic [7:0] CH_QUERY = "?";
	localparam logic [7:0] CH_LT    = "<";
	localparam logic [7:0] CH_AT    = "@";
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_COMMA = ",";

	// per-string summary handed from scanner to verdict stage
	typedef struct packed {
		logic                 nonspace;
		logic                 too_long;
		logic [NUM_FLAGS-1:0] flags;
		logic [10:0]          count;
	} summary_t;

endpackage

### hw/rtl/selector_danger_prescan_unit.sv
// Top level of the selector danger prescan unit.
//
//  channel  | beat taken when  | fields
//  ---------+------------------+---------------------------------
//  input    | push && !full    | has_byte, byte_value, last
//  result   | pop && !empty    | verdict, byte_count
//
// One input beat per cycle while full is low; the scanner has no internal stall.
// A verdict travels from its last beat through the summary queue
// and then the output register to the result ports.
// The four-entry summary queue absorbs result stalls; full rises only
// when it fills. Reset clears all string state and empties the queue.
`timescale 1ns / 1ps

module selector_danger_prescan_unit #(
	parameter int MAX_LEN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        has_byte,
	input  logic [7:0]  byte_value,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  verdict,
	output logic [10:0] byte_count
);

	logic              take;
	logic              sum_push;
	sdp_pkg::summary_t sum_data;
	logic              q_rd;
	logic              q_valid;
	sdp_pkg::summary_t q_data;

	assign take = push && !full;

	sdp_scan #(
		.MAX_LEN(MAX_LEN)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.has_byte  (has_byte),
		.byte_value(byte_value),
		.last      (last),
		.sum_push  (sum_push),
		.sum_data  (sum_data)
	);

	sdp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (sum_push),
		.wr_data (sum_data),
		.full    (full),
		.rd      (q_rd),
		.rd_valid(q_valid),
		.rd_data (q_data)
	);

	sdp_verdict u_verdict (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_rd      (q_rd),
		.empty     (empty),
		.pop       (pop),
		.verdict   (verdict),
		.byte_count(byte_count)
	);

endmodule

### hw/rtl/sdp_scan.sv
// Front end: byte history, pattern matching, length count and string summary.
`timescale 1ns / 1ps

module sdp_scan #(
	parameter int MAX_LEN = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              has_byte,
	input  logic [7:0]        byte_value,
	input  logic              last,
	output logic              sum_push,
	output sdp_pkg::summary_t sum_data
);

	localparam int CW = $clog2(MAX_LEN + 2);
	localparam logic [CW-1:0] CNT_SAT = CW'(MAX_LEN + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LEN);

	logic [10:0][7:0]              hist_q;
	logic [10:0][7:0]              hist_n;
	logic [sdp_pkg::NUM_FLAGS-1:0] flags_q;
	logic [sdp_pkg::NUM_FLAGS-1:0] flags_n;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 cnt_n;
	logic                          ns_q;
	logic                          ns_n;
	logic [CW+10:0]                cnt_ext;
	logic [7:0]                    c;
	logic                          is_ws;
	logic                          is_letter;

	always_comb begin
		c = byte_value;
		if (byte_value >= "A" && byte_value <= "Z") begin
			c = byte_value + 8'd32;
		end
		is_ws = c == sdp_pkg::CH_SPACE || c == sdp_pkg::CH_TAB || c == sdp_pkg::CH_CR ||
			c == sdp_pkg::CH_LF || c == sdp_pkg::CH_FF;
		is_letter = c >= "a" && c <= "z";

		hist_n  = hist_q;
		flags_n = flags_q;
		cnt_n   = cnt_q;
		ns_n    = ns_q;
		if (has_byte) begin
			hist_n = {hist_q[9:0], c};
			if (cnt_q != CNT_SAT) begin
				cnt_n = cnt_q + 1'b1;
			end
			if (!is_ws) begin
				ns_n = 1'b1;
			end
			if (hist_n[9:0] == sdp_pkg::PAT_IMPORTANT) begin
				flags_n[sdp_pkg::FB_IMPORTANT] = 1'b1;
			end
			if (hist_q[0] == sdp_pkg::CH_LT && (c == sdp_pkg::CH_BANG ||
				c == sdp_pkg::CH_SLASH || c == sdp_pkg::CH_QUERY || is_letter)) begin
				flags_n[sdp_pkg::FB_MARKUP] = 1'b1;
			end
			if (c == sdp_pkg::CH_AT) begin
				flags_n[sdp_pkg::FB_AT] = 1'b1;
			end
			if (hist_n[10:0] == sdp_pkg::PAT_EXPR) begin
				flags_n[sdp_pkg::FB_EXPR] = 1'b1;
			end
			if (hist_n[3:0] == sdp_pkg::PAT_URL || hist_n[9:0] == sdp_pkg::PAT_IMAGE_SET ||
				hist_n[10:0] == sdp_pkg::PAT_JS) begin
				flags_n[sdp_pkg::FB_URL] = 1'b1;
			end
			if (c == sdp_pkg::CH_BSL) begin
				flags_n[sdp_pkg::FB_ESCAPE] = 1'b1;
			end
			if ((hist_q[0] == sdp_pkg::CH_SLASH && c == sdp_pkg::CH_STAR) ||
				(hist_q[0] == sdp_pkg::CH_STAR && c == sdp_pkg::CH_SLASH)) begin
				flags_n[sdp_pkg::FB_COMMENT] = 1'b1;
			end
			if (c == sdp_pkg::CH_BANG) begin
				flags_n[sdp_pkg::FB_BANG] = 1'b1;
			end
			if (c == sdp_pkg::CH_COMMA) begin
				flags_n[sdp_pkg::FB_COMMA] = 1'b1;
			end
		end
		cnt_ext           = (CW + 11)'(cnt_n);
		sum_push          = take && last;
		sum_data.nonspace = ns_n;
		sum_data.too_long = cnt_n > CNT_MAX;
		sum_data.flags    = flags_n;
		sum_data.count    = cnt_ext[10:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			flags_q <= '0;
			cnt_q   <= '0;
			ns_q    <= 1'b0;
		end else if (take) begin
			if (last) begin
				hist_q  <= '0;
				flags_q <= '0;
				cnt_q   <= '0;
				ns_q    <= 1'b0;
			end else begin
				hist_q  <= hist_n;
				flags_q <= flags_n;
				cnt_q   <= cnt_n;
				ns_q    <= ns_n;
			end
		end
	end

endmodule

### hw/rtl/sdp_queue.sv
// Short queue of string summaries between scanner and verdict stage.
`timescale 1ns / 1ps

module sdp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  sdp_pkg::summary_t wr_data,
	output logic              full,
	input  logic              rd,
	output logic              rd_valid,
	output sdp_pkg::summary_t rd_data
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	sdp_pkg::summary_t mem [DEPTH];
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     rp_q;
	logic [AW:0]       cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full     = cnt_q == (AW + 1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem[rp_q];
	assign do_wr    = wr && !full;
	assign do_rd    = rd && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW + 1)'(do_wr) - (AW + 1)'(do_rd);
		end
	end

endmodule

### hw/rtl/sdp_verdict.sv
// Back end: priority verdict and output register.
`timescale 1ns / 1ps

module sdp_verdict (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  sdp_pkg::summary_t q_data,
	output logic              q_rd,
	output logic              empty,
	input  logic              pop,
	output logic [3:0]        verdict,
	output logic [10:0]       byte_count
);

	logic       valid_q;
	logic [3:0] verdict_q;
	logic [10:0] count_q;
	logic [3:0] v;

	always_comb begin
		if (!q_data.nonspace) begin
			v = sdp_pkg::V_EMPTY;
		end else if (q_data.too_long) begin
			v = sdp_pkg::V_TOO_LONG;
		end else if (q_data.flags[sdp_pkg::FB_IMPORTANT]) begin
			v = sdp_pkg::V_IMPORTANT;
		end else if (q_data.flags[sdp_pkg::FB_MARKUP]) begin
			v = sdp_pkg::V_MARKUP;
		end else if (q_data.flags[sdp_pkg::FB_AT]) begin
			v = sdp_pkg::V_AT_RULE;
		end else if (q_data.flags[sdp_pkg::FB_EXPR]) begin
			v = sdp_pkg::V_EXPR;
		end else if (q_data.flags[sdp_pkg::FB_URL]) begin
			v = sdp_pkg::V_URL;
		end else if (q_data.flags[sdp_pkg::FB_ESCAPE]) begin
			v = sdp_pkg::V_ESCAPE;
		end else if (q_data.flags[sdp_pkg::FB_COMMENT]) begin
			v = sdp_pkg::V_COMMENT;
		end else if (q_data.flags[sdp_pkg::FB_BANG]) begin
			v = sdp_pkg::V_BANG;
		end else if (q_data.flags[sdp_pkg::FB_COMMA]) begin
			v = sdp_pkg::V_LIST;
		end else begin
			v = sdp_pkg::V_PASS;
		end
	end

	assign q_rd       = q_valid && (!valid_q || pop);
	assign empty      = !valid_q;
	assign verdict    = verdict_q;
	assign byte_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			verdict_q <= v;
			count_q   <= q_data.count;
		end
	end

endmodule

### hw/rtl/sdp_checker.sv
// Port-level checks for the selector danger prescan unit, with its bind.
`timescale 1ns / 1ps

module sdp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        has_byte,
	input logic [7:0]  byte_value,
	input logic        last,
	input logic        empty,
	input logic        pop,
	input logic [3:0]  verdict,
	input logic [10:0] byte_count
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("result or full asserted in reset");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> verdict <= sdp_pkg::V_LIST)
		else $error("verdict code out of range");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && byte_count == 11'd0 |->
		verdict == sdp_pkg::V_EMPTY || verdict == sdp_pkg::V_TOO_LONG)
		else $error("zero length string not reported empty");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && last && empty |-> ##2 !empty)
		else $error("verdict did not arrive two cycles after last beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(verdict) && $stable(byte_count))
		else $error("stalled result changed");

endmodule

bind selector_danger_prescan_unit sdp_checker u_chk (.*);
